// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the timer queue engine
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted
`define PTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true on a rising clock edge
`define PTQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/ptq_pkg.sv =====
// ---------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants of the periodic timer queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptq_pkg;

  localparam int MAX_TIMERS_DEF = 16;
  // Most timers fired by a single check item
  localparam int RESULT_CAP     = 16;
  localparam int TIME_W         = 63;
  localparam int PER_W          = 32;
  localparam int TID_W          = 4;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  // Classified command passed from front to back
  typedef struct packed {
    logic              is_check;
    logic [TIME_W-1:0] tm;        // deadline for add, current time for check
    logic [PER_W-1:0]  interval;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [TID_W-1:0]  timer_id;
    logic              earliest_changed;
    logic              next_valid;
    logic [TIME_W-1:0] next_deadline_us;
    logic              last;
  } res_t;

endpackage

// ===== sv/ptq_ram.sv =====
// ---------------------------------------------------------------------------
// ptq_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/ptq_fifo.sv =====
// ---------------------------------------------------------------------------
// ptq_fifo
// Two-entry queue that decouples a producer from a consumer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptq_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== sv/ptq_front.sv =====
// ---------------------------------------------------------------------------
// ptq_front
// Accepts items, classifies them into add or check commands and queues them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptq_front import ptq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              action_i,
  input  logic [TIME_W-1:0] when_us_i,
  input  logic [PER_W-1:0]  interval_us_i,
  input  logic [TIME_W-1:0] now_us_i,
  input  logic              cmd_pop_i,
  output logic              cmd_empty_o,
  output cmd_t              cmd_o
);

  cmd_t                  cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  // keep only the time field the command uses
  always_comb begin
    cmd_in.is_check = (action_i == ACT_CHECK);
    cmd_in.tm       = (action_i == ACT_CHECK) ? now_us_i : when_us_i;
    cmd_in.interval = interval_us_i;
  end

  ptq_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .empty_o(cmd_empty_o),
    .data_o (cmd_raw)
  );

  assign cmd_o = cmd_t'(cmd_raw);

endmodule

// ===== sv/ptq_engine.sv =====
// ---------------------------------------------------------------------------
// ptq_engine
// Back end: scans the timer table in passes, adds, fires, reloads and frees
// timers, then streams the results of one command into the output queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptq_engine import ptq_pkg::*; #(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic out_full_i,
  output logic out_push_o,
  output res_t out_data_o
);

  localparam int IW    = $clog2(MAX_TIMERS);
  localparam int CW    = IW + 1;
  localparam int RIW   = $clog2(RESULT_CAP);
  localparam int NFW   = $clog2(RESULT_CAP + 1);
  localparam int RAM_W = PER_W + TIME_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_FIRE   = 3'd2;
  localparam logic [2:0] S_RELOAD = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  localparam logic [CW-1:0]     CNT_END = CW'(MAX_TIMERS);
  localparam logic [NFW-1:0]    NF_CAP  = NFW'(RESULT_CAP);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  cmd_t                  cmd_q, cmd_d;
  logic [MAX_TIMERS-1:0] used_q, used_d;
  logic [MAX_TIMERS-1:0] fired_q, fired_d;
  logic [IW-1:0]         ids_q [RESULT_CAP];
  logic [NFW-1:0]        nfire_q, nfire_d;
  logic                  any_q, any_d;
  logic [TIME_W-1:0]     best_q, best_d;
  logic [IW-1:0]         bidx_q, bidx_d;
  kind_e                 rkind_q, rkind_d;
  logic [IW-1:0]         rid_q, rid_d;
  logic                  rec_q, rec_d;
  logic                  nv_q, nv_d;
  logic [TIME_W-1:0]     ndl_q, ndl_d;
  logic [NFW-1:0]        emit_q, emit_d;

  // table memory: {period, deadline}
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [RAM_W-1:0]      ram_wdata;
  logic [RAM_W-1:0]      ram_rdata;

  logic                  scan_vld;
  logic [IW-1:0]         ent;
  logic [TIME_W-1:0]     rd_dl;
  logic [PER_W-1:0]      rd_per;
  logic [TIME_W:0]       sum;
  logic [TIME_W-1:0]     new_dl;
  logic                  cand;
  logic [TIME_W-1:0]     cand_dl;
  logic                  f_any;
  logic [TIME_W-1:0]     f_best;
  logic [IW-1:0]         f_idx;
  logic                  pass_end;
  logic                  tbl_full;
  logic [IW-1:0]         free_idx;
  logic                  ids_we;
  logic [NFW-1:0]        n_res;
  logic                  is_last;
  logic [IW-1:0]         out_id;

  ptq_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_TIMERS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_q[IW-1:0]),
    .rdata_o(ram_rdata)
  );

  // entry whose data is on the read port this cycle
  assign scan_vld = (cnt_q != '0);
  assign ent      = IW'(cnt_q - CW'(1));
  assign rd_dl    = ram_rdata[TIME_W-1:0];
  assign rd_per   = ram_rdata[RAM_W-1:TIME_W];
  assign pass_end = (cnt_q == CNT_END);

  // saturating reload deadline
  assign sum    = {1'b0, cmd_q.tm} + {{(TIME_W + 1 - PER_W){1'b0}}, rd_per};
  assign new_dl = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  // lowest free slot
  always_comb begin
    tbl_full = &used_q;
    free_idx = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // candidate of the current entry for this pass
  always_comb begin
    cand    = 1'b0;
    cand_dl = rd_dl;
    unique case (state_q)
      S_ADD: begin
        cand = used_q[ent];
      end
      S_FIRE: begin
        cand = used_q[ent] && !fired_q[ent] && (rd_dl <= cmd_q.tm);
      end
      S_RELOAD: begin
        if (fired_q[ent]) begin
          cand    = (rd_per != '0);
          cand_dl = new_dl;
        end else begin
          cand = used_q[ent];
        end
      end
      default: begin
        cand = 1'b0;
      end
    endcase
    cand = cand && scan_vld;
  end

  // running minimum, strict compare keeps the lowest slot on ties
  always_comb begin
    f_any  = any_q;
    f_best = best_q;
    f_idx  = bidx_q;
    if (cand && (!any_q || cand_dl < best_q)) begin
      f_any  = 1'b1;
      f_best = cand_dl;
      f_idx  = ent;
    end
  end

  // result count of the current command
  always_comb begin
    if (!cmd_q.is_check || nfire_q == '0) begin
      n_res = NFW'(1);
    end else begin
      n_res = nfire_q;
    end
    is_last = (emit_q == n_res - NFW'(1));
    // a check with nothing due reports slot 0
    out_id  = !cmd_q.is_check ? rid_q :
              (nfire_q == '0) ? '0 : ids_q[emit_q[RIW-1:0]];
  end

  // result formatting
  always_comb begin
    out_data_o.kind             = !cmd_q.is_check ? rkind_q :
                                  (nfire_q == '0) ? KIND_NONE : KIND_FIRED;
    out_data_o.timer_id         = TID_W'(out_id);
    out_data_o.earliest_changed = cmd_q.is_check ? 1'b0 : rec_q;
    out_data_o.next_valid       = nv_q;
    out_data_o.next_deadline_us = ndl_q;
    out_data_o.last             = is_last;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    used_d     = used_q;
    fired_d    = fired_q;
    nfire_d    = nfire_q;
    any_d      = f_any;
    best_d     = f_best;
    bidx_d     = f_idx;
    rkind_d    = rkind_q;
    rid_d      = rid_q;
    rec_d      = rec_q;
    nv_d       = nv_q;
    ndl_d      = ndl_q;
    emit_d     = emit_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ent;
    ram_wdata  = {rd_per, new_dl};
    ids_we     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        any_d  = 1'b0;
        best_d = '0;
        cnt_d  = '0;
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          fired_d   = '0;
          nfire_d   = '0;
          emit_d    = '0;
          state_d   = cmd_i.is_check ? S_FIRE : S_ADD;
        end
      end
      S_ADD: begin
        cnt_d = cnt_q + CW'(1);
        if (pass_end) begin
          if (tbl_full) begin
            rkind_d = KIND_ADD_FULL;
            rid_d   = '0;
            rec_d   = 1'b0;
            nv_d    = f_any;
            ndl_d   = f_best;
          end else begin
            ram_we            = 1'b1;
            ram_waddr         = free_idx;
            ram_wdata         = {cmd_q.interval, cmd_q.tm};
            used_d[free_idx]  = 1'b1;
            rkind_d           = KIND_ADD_OK;
            rid_d             = free_idx;
            rec_d             = !f_any || (cmd_q.tm < f_best);
            nv_d              = 1'b1;
            ndl_d             = (f_any && f_best < cmd_q.tm) ? f_best : cmd_q.tm;
          end
          state_d = S_EMIT;
        end
      end
      S_FIRE: begin
        cnt_d = cnt_q + CW'(1);
        if (pass_end) begin
          cnt_d  = '0;
          any_d  = 1'b0;
          best_d = '0;
          if (f_any) begin
            fired_d[f_idx] = 1'b1;
            ids_we         = 1'b1;
            nfire_d        = nfire_q + NFW'(1);
          end
          if (!f_any || nfire_q + NFW'(1) == NF_CAP) begin
            state_d = S_RELOAD;
          end
        end
      end
      S_RELOAD: begin
        cnt_d = cnt_q + CW'(1);
        if (scan_vld && fired_q[ent]) begin
          if (rd_per != '0) begin
            ram_we = 1'b1;
          end else begin
            used_d[ent] = 1'b0;
          end
        end
        if (pass_end) begin
          nv_d    = f_any;
          ndl_d   = f_best;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          emit_d     = emit_q + NFW'(1);
          if (is_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      used_q  <= '0;
      fired_q <= '0;
      nfire_q <= '0;
      emit_q  <= '0;
      any_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      fired_q <= fired_d;
      nfire_q <= nfire_d;
      emit_q  <= emit_d;
      any_q   <= any_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    best_q  <= best_d;
    bidx_q  <= bidx_d;
    rkind_q <= rkind_d;
    rid_q   <= rid_d;
    rec_q   <= rec_d;
    nv_q    <= nv_d;
    ndl_q   <= ndl_d;
    if (ids_we) begin
      ids_q[nfire_q[RIW-1:0]] <= f_idx;
    end
  end

  `PTQ_ASSERT_NEVER(a_push_full, out_push_o && out_full_i, "result pushed into full queue")
  `PTQ_ASSERT(a_nfire_cap, nfire_q <= NF_CAP, "fire count beyond result cap")
  `PTQ_ASSERT(a_pop_idle, cmd_pop_o |-> (state_q == S_IDLE && !cmd_empty_i), "bad command pop")
  `PTQ_ASSERT(a_fired_used, (state_q == S_FIRE) |-> ((fired_q & ~used_q) == '0),
              "fired timer not in use")

endmodule

// ===== sv/periodic_timer_queue_top.sv =====
// ---------------------------------------------------------------------------
// periodic_timer_queue_top
// Table of periodic and one-shot timers with add and expiry check commands.
// ---------------------------------------------------------------------------
//  channel  | handshake     | fields
//  ---------+---------------+--------------------------------------------------
//  input    | push / full   | action, when_us, interval_us, now_us
//  result   | empty / pop   | kind, timer_id, earliest_changed, next_valid,
//           |               | next_deadline_us, last
//
//  An add is taken, the table is scanned once, then its result is emitted.
//  A check firing k timers is taken, then k+1 fire scans (k at the cap of
//  RESULT_CAP) and one reload scan run, then its results go out, one a cycle
//  while there is room. Scans use the single table read port, one entry a cycle.
//  Two-entry queues sit on both sides, so either side can stall on its own.
//  Reset clears all slots at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_timer_queue_top import ptq_pkg::*; #(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              action_i,
  input  logic [TIME_W-1:0] when_us_i,
  input  logic [PER_W-1:0]  interval_us_i,
  input  logic [TIME_W-1:0] now_us_i,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        kind_o,
  output logic [TID_W-1:0]  timer_id_o,
  output logic              earliest_changed_o,
  output logic              next_valid_o,
  output logic [TIME_W-1:0] next_deadline_us_o,
  output logic              last_o
);

  cmd_t                    cmd;
  logic                    cmd_empty;
  logic                    cmd_pop;
  logic                    res_push;
  logic                    res_full;
  res_t                    res_in;
  logic [$bits(res_t)-1:0] res_raw;
  res_t                    res_out;

  ptq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .when_us_i    (when_us_i),
    .interval_us_i(interval_us_i),
    .now_us_i     (now_us_i),
    .cmd_pop_i    (cmd_pop),
    .cmd_empty_o  (cmd_empty),
    .cmd_o        (cmd)
  );

  ptq_engine #(
    .MAX_TIMERS(MAX_TIMERS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_full_i (res_full),
    .out_push_o (res_push),
    .out_data_o (res_in)
  );

  // result queue
  ptq_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_raw)
  );

  assign res_out            = res_t'(res_raw);
  assign kind_o             = res_out.kind;
  assign timer_id_o         = res_out.timer_id;
  assign earliest_changed_o = res_out.earliest_changed;
  assign next_valid_o       = res_out.next_valid;
  assign next_deadline_us_o = res_out.next_deadline_us;
  assign last_o             = res_out.last;

endmodule

// ===== bench/periodic_timer_queue_checker.sv =====
// ---------------------------------------------------------------------------
// Timer table checker
// Watches both queues of the timer block, keeps its own timer table, works
// out the results of every accepted item and compares each popped result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_timer_queue_checker import ptq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  logic              action_i,
  input  logic [TIME_W-1:0] when_us_i,
  input  logic [PER_W-1:0]  interval_us_i,
  input  logic [TIME_W-1:0] now_us_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  logic [1:0]        kind_i,
  input  logic [TID_W-1:0]  timer_id_i,
  input  logic              earliest_changed_i,
  input  logic              next_valid_i,
  input  logic [TIME_W-1:0] next_deadline_us_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                waiting_o
);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Mirror of the timer table
  logic              slot_busy [MAX_TIMERS_DEF];
  logic [TIME_W-1:0] slot_due  [MAX_TIMERS_DEF];
  logic [PER_W-1:0]  slot_rep  [MAX_TIMERS_DEF];

  res_t due_results[$];

  assign waiting_o = due_results.size();

  // Earliest pending deadline; returns 0 when nothing is pending
  function automatic logic soonest(output logic [TIME_W-1:0] dl);
    logic found;
    found = 1'b0;
    dl    = '0;
    for (int i = 0; i < MAX_TIMERS_DEF; i++) begin
      if (slot_busy[i] && (!found || slot_due[i] < dl)) begin
        dl    = slot_due[i];
        found = 1'b1;
      end
    end
    return found;
  endfunction

  // Apply one input item to the table and queue up its results
  task automatic predict_timer_step(input logic act, input logic [TIME_W-1:0] when_us,
                                    input logic [PER_W-1:0] rep_us,
                                    input logic [TIME_W-1:0] now_us);
    res_t              batch[$];
    res_t              r;
    logic [TIME_W-1:0] dl;
    logic              any;
    logic              fired [MAX_TIMERS_DEF];
    int                order[$];
    int                free_slot;
    int                best;
    logic [TIME_W:0]   sum;
    r = '0;
    if (act == ACT_ADD) begin
      free_slot = -1;
      for (int i = MAX_TIMERS_DEF - 1; i >= 0; i--)
        if (!slot_busy[i]) free_slot = i;
      if (free_slot < 0) begin
        r.kind = KIND_ADD_FULL;
      end else begin
        any = soonest(dl);
        slot_busy[free_slot] = 1'b1;
        slot_due[free_slot]  = when_us;
        slot_rep[free_slot]  = rep_us;
        r.kind             = KIND_ADD_OK;
        r.timer_id         = free_slot[TID_W-1:0];
        r.earliest_changed = !any || when_us < dl;
      end
      batch.push_back(r);
    end else begin
      for (int i = 0; i < MAX_TIMERS_DEF; i++) fired[i] = 1'b0;
      // Pick due timers by deadline, ties go to the lower slot
      while (order.size() < RESULT_CAP) begin
        best = -1;
        for (int i = 0; i < MAX_TIMERS_DEF; i++)
          if (slot_busy[i] && !fired[i] && slot_due[i] <= now_us &&
              (best < 0 || slot_due[i] < slot_due[best]))
            best = i;
        if (best < 0) break;
        fired[best] = 1'b1;
        order.push_back(best);
        r.kind     = KIND_FIRED;
        r.timer_id = best[TID_W-1:0];
        batch.push_back(r);
      end
      // Reload repeating timers (saturating), free one-shots
      foreach (order[k]) begin
        if (slot_rep[order[k]] != '0) begin
          sum = {1'b0, now_us} + slot_rep[order[k]];
          slot_due[order[k]] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        end else begin
          slot_busy[order[k]] = 1'b0;
        end
      end
      if (batch.size() == 0) begin
        r.kind = KIND_NONE;
        batch.push_back(r);
      end
    end
    // Same arming info on every result of the item
    any = soonest(dl);
    foreach (batch[k]) begin
      batch[k].next_valid       = any;
      batch[k].next_deadline_us = dl;
      batch[k].last             = (k == batch.size() - 1);
      due_results.push_back(batch[k]);
    end
  endtask

  // Compare one popped result against the oldest expectation
  task automatic compare_result();
    res_t exp_r;
    if (due_results.size() == 0) begin
      $error("result with nothing expected: kind %0d id %0d", kind_i, timer_id_i);
      fail_count_o++;
      return;
    end
    exp_r = due_results.pop_front();
    if (kind_i !== exp_r.kind) begin
      $error("kind: expected %0d, got %0d", exp_r.kind, kind_i);
      fail_count_o++;
    end
    if (timer_id_i !== exp_r.timer_id) begin
      $error("timer_id: expected %0d, got %0d", exp_r.timer_id, timer_id_i);
      fail_count_o++;
    end
    if (earliest_changed_i !== exp_r.earliest_changed) begin
      $error("earliest_changed: expected %0b, got %0b", exp_r.earliest_changed,
             earliest_changed_i);
      fail_count_o++;
    end
    if (next_valid_i !== exp_r.next_valid) begin
      $error("next_valid: expected %0b, got %0b", exp_r.next_valid, next_valid_i);
      fail_count_o++;
    end
    if (next_deadline_us_i !== exp_r.next_deadline_us) begin
      $error("next_deadline_us: expected %0d, got %0d", exp_r.next_deadline_us,
             next_deadline_us_i);
      fail_count_o++;
    end
    if (last_i !== exp_r.last) begin
      $error("last: expected %0b, got %0b", exp_r.last, last_i);
      fail_count_o++;
    end
  endtask

  // Sample both handshakes on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o = 0;
      due_results.delete();
      for (int i = 0; i < MAX_TIMERS_DEF; i++) begin
        slot_busy[i] = 1'b0;
        slot_due[i]  = '0;
        slot_rep[i]  = '0;
      end
    end else begin
      if (pop_i && !empty_i) compare_result();
      if (push_i && !full_i)
        predict_timer_step(action_i, when_us_i, interval_us_i, now_us_i);
    end
  end

endmodule

// ===== bench/periodic_timer_queue_top_test.sv =====
// ---------------------------------------------------------------------------
// periodic_timer_queue_top testbench
// Directed adds and checks around table full, equal deadlines and time
// extremes, then random add/check traffic with random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_timer_queue_top_test;
  import ptq_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam int                NUM_RAND  = 380;
  localparam int                QUIET_TAIL = 40;
  localparam int                STALL_LIMIT = 5000;
  localparam int                DRAIN_CYCLES = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              action_i = ACT_ADD;
  logic [TIME_W-1:0] when_us_i = '0;
  logic [PER_W-1:0]  interval_us_i = '0;
  logic [TIME_W-1:0] now_us_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        kind_o;
  logic [TID_W-1:0]  timer_id_o;
  logic              earliest_changed_o;
  logic              next_valid_o;
  logic [TIME_W-1:0] next_deadline_us_o;
  logic              last_o;

  int                fail_count;
  int                waiting;
  int                stall_cycles = 0;
  int                pop_hold = 0;
  logic              idle_on = 1'b1;
  logic [TIME_W-1:0] sim_now = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  periodic_timer_queue_top DUT (
    .clk_i, .rst_ni, .push, .full, .action_i, .when_us_i, .interval_us_i,
    .now_us_i, .empty, .pop, .kind_o, .timer_id_o, .earliest_changed_o,
    .next_valid_o, .next_deadline_us_o, .last_o
  );

  periodic_timer_queue_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .action_i, .when_us_i,
    .interval_us_i, .now_us_i, .empty_i(empty), .pop_i(pop), .kind_i(kind_o),
    .timer_id_i(timer_id_o), .earliest_changed_i(earliest_changed_o),
    .next_valid_i(next_valid_o), .next_deadline_us_i(next_deadline_us_o),
    .last_i(last_o), .fail_count_o(fail_count), .waiting_o(waiting)
  );

  // Result side: pop with random stall bursts
  always @(posedge clk_i) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (idle_on && rst_ni && $urandom_range(0, 5) == 0) begin
      pop_hold <= $urandom_range(0, 2);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** periodic_timer_queue_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // Offer one item, optionally after a short gap, and wait for acceptance
  task automatic send_item(input logic act, input logic [TIME_W-1:0] when_us,
                           input logic [PER_W-1:0] rep_us,
                           input logic [TIME_W-1:0] now_us);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push          <= 1'b1;
    action_i      <= act;
    when_us_i     <= when_us;
    interval_us_i <= rep_us;
    now_us_i      <= now_us;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  initial begin
    logic [TIME_W-1:0] w;
    logic [PER_W-1:0]  p;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty check, extreme deadlines and periods, ties, full table
    send_item(ACT_CHECK, '0, '0, '0);
    send_item(ACT_ADD, TIME_MAX, '0, '0);
    send_item(ACT_ADD, '0, '1, '0);
    send_item(ACT_ADD, '0, 32'd5, '0);
    send_item(ACT_ADD, 63'd100, '0, '0);
    for (int i = 0; i < 12; i++) send_item(ACT_ADD, 63'd50, i[PER_W-1:0], '0);
    send_item(ACT_ADD, 63'd1, 32'd1, '0);
    send_item(ACT_CHECK, '0, '0, 63'd50);
    send_item(ACT_CHECK, '0, '0, TIME_MAX);
    send_item(ACT_CHECK, '0, '0, TIME_MAX);

    // Random traffic around a moving time base, after one more check at the largest time
    send_item(ACT_CHECK, '0, '0, TIME_MAX);
    for (int n = 0; n < NUM_RAND; n++) begin
      if (n == NUM_RAND - QUIET_TAIL) idle_on = 1'b0;
      case ($urandom_range(0, 19))
        0: send_item(ACT_ADD, rand_time(), $urandom(), rand_time());
        1: send_item(ACT_CHECK, rand_time(), $urandom(), rand_time());
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          w = sim_now + $urandom_range(0, 3000);
          p = ($urandom_range(0, 2) == 0) ? '0 : $urandom_range(1, 2000);
          send_item(ACT_ADD, w, p, rand_time());
        end
        default: begin
          sim_now = sim_now + $urandom_range(0, 1500);
          send_item(ACT_CHECK, rand_time(), $urandom(), sim_now);
        end
      endcase
    end
    push <= 1'b0;

    wait (waiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && waiting == 0) begin
      $display("** periodic_timer_queue_top: PASSED **");
    end else begin
      $display("** periodic_timer_queue_top: FAILED **");
    end
    $finish;
  end

endmodule
